### rtl/rpmcl_pkg.sv
// Shared types and constants for the rpm current limit scheduler.
`timescale 1ns / 1ps

package rpmcl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH  = 120;
  localparam int ROM_SIZE     = 120;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int LIMIT_W      = 12;

  // rpm to index scaling: idx = rpm / 40 = (rpm >> 3) / 5
  localparam int RPM_PER_STEP = 40;
  localparam int SAT_RPM      = (TABLE_DEPTH - 1) * RPM_PER_STEP;
  localparam int RECIP_5      = 205;  // ceil(1024 / 5), exact for values below 1024
  localparam int RECIP_SHIFT  = 10;

  // Timeout register
  localparam int             TIMEOUT_W     = 8;
  localparam logic [7:0]     TIMEOUT_RESET = 8'd10;

  // Item kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MSG  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_STD = 2'd1,
    MODE_ALT = 2'd2
  } mode_t;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // Lookup request from the control path to the table
  typedef struct packed {
    idx_t idx;
    logic alt;
  } lut_req_t;

endpackage

### rtl/rpm_current_limit_scheduler_unit.sv
// Top level of the rpm current limit scheduler: input stage, control, result stage.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Word contents
// in_      input      in_valid/in_ready    action, rpm, cmd_byte0, cmd_byte2, cmd_byte3
// out_     output     out_valid/out_ready  current_limit, motor_enable, mode
// cfg_     input      cfg_valid/cfg_ready  cfg_data = message_timeout
//
// Flow: one word per cycle while out_ready is high; a word passes through the
//   input register, then the mode/limit/counter registers, to the outputs.
// Reset: synchronous active-low; mode off, limit 0, counter 0, timeout 10.
// Stalls: when out_ready is low the result holds; the input register still takes
//   one more word, then in_ready drops until the result is taken.
// cfg_ready is always high; the timeout register is written on the handshake.

module rpm_current_limit_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic signed [15:0] in_rpm,
  input  logic [7:0]  in_cmd_byte0,
  input  logic [7:0]  in_cmd_byte2,
  input  logic [7:0]  in_cmd_byte3,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_current_limit,
  output logic        out_motor_enable,
  output logic [1:0]  out_mode,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_action_r;
  logic signed [15:0] s1_rpm_r;
  logic               s1_any02_r;   // byte2 or byte3 nonzero
  logic               s1_b0_r;      // byte0 nonzero
  logic               s1_adv;       // input register hands its word to the result stage
  logic               in_acc;

  // Result stage: state registers double as the result word
  logic                    out_valid_r, out_valid_nxt;
  rpmcl_pkg::mode_t        mode_r, mode_nxt;
  logic [7:0]              silence_r, silence_nxt;
  rpmcl_pkg::limit_t       limit_r, limit_nxt;
  logic                    enable_r, enable_nxt;
  logic [rpmcl_pkg::TIMEOUT_W-1:0] timeout_r;

  rpmcl_pkg::lut_req_t lut_req;
  rpmcl_pkg::limit_t   lut_limit;

  logic [14:0] rpm_mag;
  logic [9:0]  rpm_div8;
  logic [17:0] recip_prod;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload: reduce the command bytes to flags on the way in
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_rpm_r    <= in_rpm;
      s1_b0_r     <= (in_cmd_byte0 != 8'd0);
      s1_any02_r  <= (in_cmd_byte2 != 8'd0) || (in_cmd_byte3 != 8'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Speed to table index: negative gives 0, saturate at the last step,
  // otherwise (rpm >> 3) / 5 by reciprocal multiply.
  // ---------------------------------------------------------------------------
  assign rpm_mag    = s1_rpm_r[14:0];
  assign rpm_div8   = rpm_mag[12:3];
  assign recip_prod = 18'(rpm_div8) * 18'(rpmcl_pkg::RECIP_5);

  always_comb begin
    if (s1_rpm_r[15]) begin
      lut_req.idx = '0;
    end else if (rpm_mag >= 15'(rpmcl_pkg::SAT_RPM)) begin
      lut_req.idx = rpmcl_pkg::IDX_W'(rpmcl_pkg::TABLE_DEPTH - 1);
    end else begin
      lut_req.idx = recip_prod[rpmcl_pkg::RECIP_SHIFT +: rpmcl_pkg::IDX_W];
    end
    lut_req.alt = (mode_r == rpmcl_pkg::MODE_ALT);
  end

  rpmcl_limit_lut u_lut (
    .req   (lut_req),
    .limit (lut_limit)
  );

  // ---------------------------------------------------------------------------
  // Mode, counter and limit update
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_nxt      = mode_r;
    silence_nxt   = silence_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      if (s1_action_r == rpmcl_pkg::ACT_MSG) begin
        // Message: clear the silence count, pick the mode from the bytes
        silence_nxt = '0;
        if (s1_b0_r) begin
          mode_nxt = rpmcl_pkg::MODE_ALT;
        end else if (s1_any02_r) begin
          mode_nxt = rpmcl_pkg::MODE_STD;
        end else begin
          mode_nxt = rpmcl_pkg::MODE_OFF;
        end
      end else begin
        // Tick: latch the table value, then drop to off on timeout or else count the tick
        limit_nxt = lut_limit;
        if (silence_r > timeout_r) begin
          mode_nxt = rpmcl_pkg::MODE_OFF;
        end else begin
          silence_nxt = silence_r + 8'd1;
        end
      end
    end
    enable_nxt = (mode_nxt != rpmcl_pkg::MODE_OFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= rpmcl_pkg::MODE_OFF;
      silence_r   <= '0;
      limit_r     <= '0;
      enable_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      silence_r   <= silence_nxt;
      limit_r     <= limit_nxt;
      enable_r    <= enable_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Timeout register
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rpmcl_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_limit = limit_r;
  assign out_motor_enable  = enable_r;
  assign out_mode          = mode_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_enable_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (enable_r == (mode_r != rpmcl_pkg::MODE_OFF)))
    else $error("motor enable disagrees with mode");

  a_msg_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == rpmcl_pkg::ACT_MSG) |=> (silence_r == 8'd0))
    else $error("message did not clear silence count");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == rpmcl_pkg::ACT_TICK && silence_r <= timeout_r)
    |=> (silence_r == $past(silence_r) + 8'd1))
    else $error("silent tick did not advance the counter");

  a_timeout_off: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_action_r == rpmcl_pkg::ACT_TICK && silence_r > timeout_r)
    |=> (mode_r == rpmcl_pkg::MODE_OFF && silence_r == $past(silence_r)))
    else $error("timeout did not force mode off");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(mode_r) && $stable(limit_r) && $stable(silence_r)))
    else $error("state changed without a word");

endmodule

### rtl/rpmcl_limit_lut.sv
// Current limit tables: standard and alternate, indexed by speed step.
`timescale 1ns / 1ps

module rpmcl_limit_lut (
  input  rpmcl_pkg::lut_req_t req,
  output rpmcl_pkg::limit_t   limit
);

  localparam logic [11:0] STD_ROM [rpmcl_pkg::ROM_SIZE] = '{
    12'd2045, 12'd2105, 12'd2164, 12'd2224, 12'd2283, 12'd2343, 12'd2402, 12'd2462,
    12'd2522, 12'd2581, 12'd2590, 12'd2586, 12'd2582, 12'd2579, 12'd2575, 12'd2571,
    12'd2567, 12'd2564, 12'd2560, 12'd2556, 12'd2553, 12'd2549, 12'd2545, 12'd2541,
    12'd2538, 12'd2518, 12'd2497, 12'd2477, 12'd2457, 12'd2437, 12'd2417, 12'd2397,
    12'd2377, 12'd2357, 12'd2337, 12'd2317, 12'd2296, 12'd2276, 12'd2256, 12'd2236,
    12'd2216, 12'd2196, 12'd2176, 12'd2156, 12'd2136, 12'd2116, 12'd2095, 12'd2075,
    12'd2055, 12'd2035, 12'd2009, 12'd2008, 12'd2007, 12'd2007, 12'd2006, 12'd2006,
    12'd2005, 12'd2005, 12'd2004, 12'd2004, 12'd2003, 12'd2003, 12'd2002, 12'd2002,
    12'd2001, 12'd2001, 12'd2000, 12'd2000, 12'd1999, 12'd1999, 12'd1998, 12'd1998,
    12'd1997, 12'd1997, 12'd1996, 12'd1995, 12'd1995, 12'd1994, 12'd1994, 12'd1993,
    12'd1993, 12'd1992, 12'd1992, 12'd1991, 12'd1991, 12'd1990, 12'd1990, 12'd1989,
    12'd1989, 12'd1988, 12'd1988, 12'd1987, 12'd1987, 12'd1986, 12'd1986, 12'd1985,
    12'd1985, 12'd1984, 12'd1983, 12'd1983, 12'd1982, 12'd1982, 12'd1981, 12'd1981,
    12'd1980, 12'd1980, 12'd1979, 12'd1979, 12'd1978, 12'd1978, 12'd1977, 12'd1977,
    12'd1976, 12'd1976, 12'd1975, 12'd1975, 12'd1974, 12'd1974, 12'd1973, 12'd1973
  };

  localparam logic [11:0] ALT_ROM [rpmcl_pkg::ROM_SIZE] = '{
    12'd1975, 12'd2026, 12'd2078, 12'd2129, 12'd2180, 12'd2232, 12'd2283, 12'd2334,
    12'd2386, 12'd2437, 12'd2466, 12'd2462, 12'd2458, 12'd2455, 12'd2451, 12'd2447,
    12'd2443, 12'd2440, 12'd2436, 12'd2432, 12'd2428, 12'd2425, 12'd2421, 12'd2417,
    12'd2396, 12'd2379, 12'd2362, 12'd2345, 12'd2328, 12'd2311, 12'd2293, 12'd2276,
    12'd2259, 12'd2242, 12'd2225, 12'd2208, 12'd2191, 12'd2174, 12'd2156, 12'd2139,
    12'd2122, 12'd2105, 12'd2088, 12'd2071, 12'd2054, 12'd2037, 12'd2019, 12'd2002,
    12'd1985, 12'd1968, 12'd1970, 12'd1970, 12'd1970, 12'd1969, 12'd1969, 12'd1969,
    12'd1968, 12'd1968, 12'd1968, 12'd1968, 12'd1967, 12'd1967, 12'd1967, 12'd1966,
    12'd1966, 12'd1966, 12'd1966, 12'd1965, 12'd1965, 12'd1965, 12'd1964, 12'd1964,
    12'd1964, 12'd1963, 12'd1963, 12'd1963, 12'd1963, 12'd1962, 12'd1962, 12'd1962,
    12'd1961, 12'd1961, 12'd1961, 12'd1960, 12'd1960, 12'd1960, 12'd1960, 12'd1959,
    12'd1959, 12'd1959, 12'd1958, 12'd1958, 12'd1958, 12'd1957, 12'd1957, 12'd1957,
    12'd1957, 12'd1956, 12'd1956, 12'd1956, 12'd1955, 12'd1955, 12'd1955, 12'd1954,
    12'd1954, 12'd1954, 12'd1954, 12'd1953, 12'd1953, 12'd1953, 12'd1952, 12'd1952,
    12'd1952, 12'd1952, 12'd1951, 12'd1951, 12'd1951, 12'd1950, 12'd1950, 12'd1950
  };

  // Indices past the stored table read as zero
  always_comb begin
    if (32'(req.idx) >= 32'(rpmcl_pkg::ROM_SIZE)) begin
      limit = '0;
    end else if (req.alt) begin
      limit = ALT_ROM[req.idx];
    end else begin
      limit = STD_ROM[req.idx];
    end
  end

endmodule

### tb/tb_rpm_current_limit_scheduler_unit.sv
// Self-checking testbench for the rpm current limit scheduler top level.
`timescale 1ns / 1ps

module tb_rpm_current_limit_scheduler_unit;

  localparam int CLK_HALF      = 10;      // 20 ns period
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;       // pipeline is two deep; give it a margin
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_WORDS   = 340;
  localparam int HOLD_CYCLES   = 200;

  localparam int ROM_SIZE = rpmcl_pkg::ROM_SIZE;
  localparam int LIMIT_W  = rpmcl_pkg::LIMIT_W;

  // Limit tables, entry 0 in the top twelve bits
  localparam logic [ROM_SIZE*LIMIT_W-1:0] STD_LIMITS = {
    12'd2045, 12'd2105, 12'd2164, 12'd2224, 12'd2283, 12'd2343, 12'd2402, 12'd2462,
    12'd2522, 12'd2581, 12'd2590, 12'd2586, 12'd2582, 12'd2579, 12'd2575, 12'd2571,
    12'd2567, 12'd2564, 12'd2560, 12'd2556, 12'd2553, 12'd2549, 12'd2545, 12'd2541,
    12'd2538, 12'd2518, 12'd2497, 12'd2477, 12'd2457, 12'd2437, 12'd2417, 12'd2397,
    12'd2377, 12'd2357, 12'd2337, 12'd2317, 12'd2296, 12'd2276, 12'd2256, 12'd2236,
    12'd2216, 12'd2196, 12'd2176, 12'd2156, 12'd2136, 12'd2116, 12'd2095, 12'd2075,
    12'd2055, 12'd2035, 12'd2009, 12'd2008, 12'd2007, 12'd2007, 12'd2006, 12'd2006,
    12'd2005, 12'd2005, 12'd2004, 12'd2004, 12'd2003, 12'd2003, 12'd2002, 12'd2002,
    12'd2001, 12'd2001, 12'd2000, 12'd2000, 12'd1999, 12'd1999, 12'd1998, 12'd1998,
    12'd1997, 12'd1997, 12'd1996, 12'd1995, 12'd1995, 12'd1994, 12'd1994, 12'd1993,
    12'd1993, 12'd1992, 12'd1992, 12'd1991, 12'd1991, 12'd1990, 12'd1990, 12'd1989,
    12'd1989, 12'd1988, 12'd1988, 12'd1987, 12'd1987, 12'd1986, 12'd1986, 12'd1985,
    12'd1985, 12'd1984, 12'd1983, 12'd1983, 12'd1982, 12'd1982, 12'd1981, 12'd1981,
    12'd1980, 12'd1980, 12'd1979, 12'd1979, 12'd1978, 12'd1978, 12'd1977, 12'd1977,
    12'd1976, 12'd1976, 12'd1975, 12'd1975, 12'd1974, 12'd1974, 12'd1973, 12'd1973
  };

  localparam logic [ROM_SIZE*LIMIT_W-1:0] ALT_LIMITS = {
    12'd1975, 12'd2026, 12'd2078, 12'd2129, 12'd2180, 12'd2232, 12'd2283, 12'd2334,
    12'd2386, 12'd2437, 12'd2466, 12'd2462, 12'd2458, 12'd2455, 12'd2451, 12'd2447,
    12'd2443, 12'd2440, 12'd2436, 12'd2432, 12'd2428, 12'd2425, 12'd2421, 12'd2417,
    12'd2396, 12'd2379, 12'd2362, 12'd2345, 12'd2328, 12'd2311, 12'd2293, 12'd2276,
    12'd2259, 12'd2242, 12'd2225, 12'd2208, 12'd2191, 12'd2174, 12'd2156, 12'd2139,
    12'd2122, 12'd2105, 12'd2088, 12'd2071, 12'd2054, 12'd2037, 12'd2019, 12'd2002,
    12'd1985, 12'd1968, 12'd1970, 12'd1970, 12'd1970, 12'd1969, 12'd1969, 12'd1969,
    12'd1968, 12'd1968, 12'd1968, 12'd1968, 12'd1967, 12'd1967, 12'd1967, 12'd1966,
    12'd1966, 12'd1966, 12'd1966, 12'd1965, 12'd1965, 12'd1965, 12'd1964, 12'd1964,
    12'd1964, 12'd1963, 12'd1963, 12'd1963, 12'd1963, 12'd1962, 12'd1962, 12'd1962,
    12'd1961, 12'd1961, 12'd1961, 12'd1960, 12'd1960, 12'd1960, 12'd1960, 12'd1959,
    12'd1959, 12'd1959, 12'd1958, 12'd1958, 12'd1958, 12'd1957, 12'd1957, 12'd1957,
    12'd1957, 12'd1956, 12'd1956, 12'd1956, 12'd1955, 12'd1955, 12'd1955, 12'd1954,
    12'd1954, 12'd1954, 12'd1954, 12'd1953, 12'd1953, 12'd1953, 12'd1952, 12'd1952,
    12'd1952, 12'd1952, 12'd1951, 12'd1951, 12'd1951, 12'd1950, 12'd1950, 12'd1950
  };

  // One input word and one result word as the ports carry them
  typedef struct packed {
    logic               action;
    logic signed [15:0] rpm;
    logic [7:0]         cmd_byte0;
    logic [7:0]         cmd_byte2;
    logic [7:0]         cmd_byte3;
  } speed_word_t;

  typedef struct packed {
    rpmcl_pkg::limit_t current_limit;
    logic              motor_enable;
    rpmcl_pkg::mode_t  mode;
  } limit_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  speed_word_t drive_word;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_current_limit;
  logic        out_motor_enable;
  logic [1:0]  out_mode;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // Predicted scheduler state, mirrors the block from reset on
  rpmcl_pkg::mode_t  pred_mode    = rpmcl_pkg::MODE_OFF;
  logic [7:0]        pred_silence = 8'd0;
  rpmcl_pkg::limit_t pred_limit   = '0;
  logic [7:0]        pred_timeout = rpmcl_pkg::TIMEOUT_RESET;

  limit_result_t expected_limits_q[$];

  int fail_count      = 0;
  int words_sent      = 0;
  int messages_sent   = 0;
  int results_checked = 0;
  int timeouts_fired  = 0;
  int alt_lookups     = 0;
  int cycle_count     = 0;

  // Throttle knobs, written by the test sequence right after a rising edge
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_left       = 0;

  rpm_current_limit_scheduler_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (drive_word.action),
    .in_rpm            (drive_word.rpm),
    .in_cmd_byte0      (drive_word.cmd_byte0),
    .in_cmd_byte2      (drive_word.cmd_byte2),
    .in_cmd_byte3      (drive_word.cmd_byte3),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_limit (out_current_limit),
    .out_motor_enable  (out_motor_enable),
    .out_mode          (out_mode),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic rpmcl_pkg::limit_t limit_entry(input logic alternate, input int idx);
    if (idx >= ROM_SIZE) begin
      return '0;
    end
    return alternate ? ALT_LIMITS[(ROM_SIZE-1-idx)*LIMIT_W +: LIMIT_W]
                     : STD_LIMITS[(ROM_SIZE-1-idx)*LIMIT_W +: LIMIT_W];
  endfunction

  // Advance the predicted state by one word and return the result it causes.
  function automatic limit_result_t schedule_limit(input speed_word_t w);
    int            idx;
    limit_result_t r;
    if (w.action == rpmcl_pkg::ACT_MSG) begin
      pred_silence = 8'd0;
      if (w.cmd_byte0 != 8'd0) begin
        pred_mode = rpmcl_pkg::MODE_ALT;
      end else if (w.cmd_byte2 != 8'd0 || w.cmd_byte3 != 8'd0) begin
        pred_mode = rpmcl_pkg::MODE_STD;
      end else begin
        pred_mode = rpmcl_pkg::MODE_OFF;
      end
    end else begin
      // Negative speed reads entry 0; the index is clamped, never cut to 8 bits.
      if (w.rpm[15]) begin
        idx = 0;
      end else begin
        idx = int'(w.rpm[14:0]) / rpmcl_pkg::RPM_PER_STEP;
      end
      if (idx > rpmcl_pkg::TABLE_DEPTH - 1) begin
        idx = rpmcl_pkg::TABLE_DEPTH - 1;
      end
      if (pred_mode == rpmcl_pkg::MODE_ALT) begin
        alt_lookups++;
      end
      pred_limit = limit_entry(pred_mode == rpmcl_pkg::MODE_ALT, idx);
      // The lookup uses the mode from before the timeout test.
      if (pred_silence > pred_timeout) begin
        pred_mode = rpmcl_pkg::MODE_OFF;
        timeouts_fired++;
      end else begin
        pred_silence = pred_silence + 8'd1;
      end
    end
    r.current_limit = pred_limit;
    r.motor_enable  = (pred_mode != rpmcl_pkg::MODE_OFF);
    r.mode          = pred_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge. Pop the finished word
  // before pushing the new one; a word accepted now cannot leave in this cycle.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    limit_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        pred_timeout = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_limits_q.size() == 0) begin
          $display("%0t: result with no word pending: limit %0d enable %0b mode %0d",
                   $time, out_current_limit, out_motor_enable, out_mode);
          fail_count++;
        end else begin
          want = expected_limits_q.pop_front();
          results_checked++;
          if (out_current_limit !== want.current_limit) begin
            $display("%0t: current_limit expected %0d actual %0d",
                     $time, want.current_limit, out_current_limit);
            fail_count++;
          end
          if (out_motor_enable !== want.motor_enable) begin
            $display("%0t: motor_enable expected %0b actual %0b",
                     $time, want.motor_enable, out_motor_enable);
            fail_count++;
          end
          if (out_mode !== want.mode) begin
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, out_mode);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_limits_q.push_back(schedule_limit(drive_word));
        words_sent++;
        if (drive_word.action == rpmcl_pkg::ACT_MSG) begin
          messages_sent++;
        end
      end
    end
  end

  // Receiver: drop ready at random, or hold it low for a counted stretch.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: stop a run that hangs on a handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending",
               $time, cycle_count, expected_limits_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one word at a falling edge, after random idle cycles, and hold it
  // until the rising edge that accepts it.
  task automatic send_word(input speed_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drive_word <= w;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Ticks carry random command bytes and messages a random rpm; both are ignored.
  task automatic send_tick(input logic [15:0] rpm);
    speed_word_t w;
    w.action    = rpmcl_pkg::ACT_TICK;
    w.rpm       = rpm;
    w.cmd_byte0 = 8'($urandom);
    w.cmd_byte2 = 8'($urandom);
    w.cmd_byte3 = 8'($urandom);
    send_word(w);
  endtask

  task automatic send_message(input logic [7:0] b0, input logic [7:0] b2,
                              input logic [7:0] b3);
    speed_word_t w;
    w.action    = rpmcl_pkg::ACT_MSG;
    w.rpm       = 16'($urandom);
    w.cmd_byte0 = b0;
    w.cmd_byte2 = b2;
    w.cmd_byte3 = b3;
    send_word(w);
  endtask

  // Drop valid and wait until every expected result is back, plus a margin.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_limits_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the timeout register only once the block has gone idle.
  task automatic write_timeout(input logic [7:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(input int zero_pct);
    if ($urandom_range(99) < zero_pct) begin
      return 8'd0;
    end
    if ($urandom_range(9) == 0) begin
      return 8'hff;
    end
    return 8'($urandom_range(255, 1));
  endfunction

  // Mostly speeds inside the table, with step edges, saturation and negatives.
  function automatic logic [15:0] pick_rpm();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom_range(4800, 0));
      5: return 16'(rpmcl_pkg::RPM_PER_STEP * $urandom_range(rpmcl_pkg::TABLE_DEPTH) +
                    ($urandom_range(1) ? rpmcl_pkg::RPM_PER_STEP - 1 : 0));
      6: return 16'($urandom_range(32767, 4760));
      7: return 16'(-int'($urandom_range(32768, 1)));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_word(input int msg_pct);
    if ($urandom_range(99) < msg_pct) begin
      send_message(pick_byte(60), pick_byte(50), pick_byte(50));
    end else begin
      send_tick(pick_rpm());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every mode select, and the fallback at the reset timeout.
  task automatic test_directed_cases();
    int k;
    send_tick(16'd0);          // reset state: mode off, standard table
    send_tick(16'sh8000);      // most negative speed reads entry 0
    send_tick(16'd39);
    send_tick(16'd40);         // first step boundary
    send_tick(16'd4760);       // last entry
    send_tick(16'sh7fff);      // clamp
    send_message(8'hff, 8'd0, 8'd0);
    send_tick(16'd4799);       // alternate table, last entry
    send_tick(16'hffff);       // alternate table, negative
    send_message(8'd1, 8'hff, 8'hff);
    send_message(8'd0, 8'hff, 8'd0);
    send_tick(16'd400);
    send_message(8'd0, 8'd0, 8'd0);
    send_message(8'd0, 8'd0, 8'hff);
    // Count past the reset timeout of ten; the twelfth tick drops the mode.
    for (k = 0; k < 12; k++) begin
      send_tick(16'(k * 397));
    end
  endtask

  // Timeout of zero, the never-firing maximum with counter wrap, and a lowered
  // timeout that fires on the very next tick.
  task automatic test_timeout_limits();
    write_timeout(8'd0);
    send_message(8'd0, 8'd1, 8'd0);
    repeat (3) send_tick(pick_rpm());
    write_timeout(8'hff);
    send_message(8'd0, 8'd0, 8'd9);
    repeat (300) send_tick(pick_rpm());
    write_timeout(8'd5);
    repeat (3) send_tick(pick_rpm());
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [7:0] timeout,
                           input int msg_pct);
    write_timeout(timeout);
    @(posedge clk);
    sender_idle_pct = idle;
    stall_pct       = stall;
    repeat (PHASE_WORDS) send_random_word(msg_pct);
  endtask

  task automatic test_random_phases();
    run_phase(0, 0, 8'd3, 20);
    run_phase(83, 0, 8'd0, 25);
    run_phase(0, 83, 8'd254, 10);
    run_phase(34, 34, 8'($urandom_range(8, 1)), 15);
  endtask

  // Hold the receiver off while the sender keeps offering words back to back.
  task automatic test_input_backpressure();
    write_timeout(8'($urandom_range(6, 2)));
    @(posedge clk);
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left       = HOLD_CYCLES;
    repeat (60) send_random_word(20);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    drive_word = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_timeout_limits();
    test_random_phases();
    test_input_backpressure();
    wait_for_results();

    $display("Sent %0d words (%0d messages), checked %0d results.",
             words_sent, messages_sent, results_checked);
    $display("Timeout fallback seen %0d times, alternate table read %0d times.",
             timeouts_fired, alt_lookups);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
